// ----- hw/rtl/psp_pkg.sv -----
// ----------------------------------------------------------------------------
// PGM stream parser package
// Shared types, character codes and result builders for the grey-map parser.
// ----------------------------------------------------------------------------
package psp_pkg;

   // Default width of the decimal number accumulator.
   localparam int NUMBER_BITS_DEF = 16;

   // Result queue geometry: one byte gives at most two results.
   localparam int MAX_RESULTS  = 2;
   localparam int RES_DEPTH    = 4;
   localparam int RES_PTR_BITS = 2;
   localparam int RES_CNT_BITS = 3;

   // Character codes.
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_FIVE  = 8'h35;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_MAGIC       = 3'd0,
      ERR_CORRUPT     = 3'd1,
      ERR_ZERO_WIDTH  = 3'd2,
      ERR_ZERO_HEIGHT = 3'd3,
      ERR_TOO_LARGE   = 3'd4
   } err_type;

   typedef enum logic [12:0] {
      PH_EXPECT_P = 13'b0000000000001,
      PH_KIND     = 13'b0000000000010,
      PH_GAP_W    = 13'b0000000000100,
      PH_NUM_W    = 13'b0000000001000,
      PH_GAP_H    = 13'b0000000010000,
      PH_NUM_H    = 13'b0000000100000,
      PH_GAP_M    = 13'b0000001000000,
      PH_NUM_M    = 13'b0000010000000,
      PH_PIX_GAP  = 13'b0000100000000,
      PH_PIX_NUM  = 13'b0001000000000,
      PH_PIX_BIN  = 13'b0010000000000,
      PH_DONE     = 13'b0100000000000,
      PH_ERROR    = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [15:0] max_value;
      logic        binary_mode;
      logic        maxval_warning;
      logic [15:0] pixel_value;
      logic [15:0] column;
      logic [15:0] row;
      logic        final_pixel;
      err_type     error_code;
      logic        last;
   } result_type;

   function automatic result_type error_result(input err_type code);
      result_type r;
      r             = '0;
      r.result_kind = KIND_ERROR;
      r.error_code  = code;
      return r;
   endfunction

   function automatic result_type pixel_result(input logic [15:0] value,
                                               input logic [15:0] col,
                                               input logic [15:0] row_idx,
                                               input logic        fin);
      result_type r;
      r             = '0;
      r.result_kind = KIND_PIXEL;
      r.pixel_value = value;
      r.column      = col;
      r.row         = row_idx;
      r.final_pixel = fin;
      return r;
   endfunction

   function automatic result_type header_result(input logic [15:0] w,
                                                input logic [15:0] h,
                                                input logic [15:0] m,
                                                input logic        bin,
                                                input logic        warn);
      result_type r;
      r                = '0;
      r.result_kind    = KIND_HEADER;
      r.image_width    = w;
      r.image_height   = h;
      r.max_value      = m;
      r.binary_mode    = bin;
      r.maxval_warning = warn;
      return r;
   endfunction

endpackage

// ----- hw/rtl/psp_parser.sv -----
// ----------------------------------------------------------------------------
// PGM stream parser: parse engine
// Holds the parse state and turns one registered byte into up to two results.
// ----------------------------------------------------------------------------
module psp_parser import psp_pkg::*; #(
   parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  logic [7:0] data_byte,
   input  logic       end_of_file,
   output result_type res0,
   output result_type res1,
   output logic [1:0] res_count
);

   phase_type              phase_ff, phase_in;
   logic                   comment_ff, comment_in;
   logic                   ovf_ff, ovf_in;
   logic                   binary_ff, binary_in;
   logic [NUMBER_BITS-1:0] acc_ff, acc_in;
   logic [NUMBER_BITS-1:0] width_ff, width_in;
   logic [NUMBER_BITS-1:0] height_ff, height_in;
   logic [NUMBER_BITS-1:0] col_ff, col_in;
   logic [NUMBER_BITS-1:0] row_ff, row_in;

   logic                   is_ws, is_digit, is_hash, is_crlf, gap_err;
   logic [3:0]             digit_val;
   logic [NUMBER_BITS+3:0] acc_step;
   logic                   acc_sat;
   logic [NUMBER_BITS-1:0] acc_next_digit;
   logic                   pix_fin;
   logic [NUMBER_BITS-1:0] col_step, row_step;

   function automatic logic [15:0] fit16(input logic [NUMBER_BITS-1:0] v);
      logic [NUMBER_BITS+15:0] wide;
      wide = {16'd0, v};
      return wide[15:0];
   endfunction

   // Byte classes; the end-of-file mark carries no byte.
   assign is_ws    = !end_of_file && ((data_byte == CH_SPACE) ||
                     ((data_byte >= CH_TAB) && (data_byte <= CH_CR)));
   assign is_digit = !end_of_file && (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign is_hash  = !end_of_file && (data_byte == CH_HASH);
   assign is_crlf  = !end_of_file && ((data_byte == CH_LF) || (data_byte == CH_CR));
   assign digit_val = data_byte[3:0];

   // acc * 10 + digit as shift-and-add, saturating at the all-ones value.
   assign acc_step = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                     + {{NUMBER_BITS{1'b0}}, digit_val};
   assign acc_sat  = |acc_step[NUMBER_BITS+3:NUMBER_BITS];
   assign acc_next_digit = acc_sat ? {NUMBER_BITS{1'b1}} : acc_step[NUMBER_BITS-1:0];

   // A gap before a header number fails on end of file or a stray byte.
   assign gap_err = end_of_file || (!comment_ff && !is_ws && !is_hash && !is_digit);

   assign pix_fin  = (row_ff == height_ff - 1'b1) && (col_ff == width_ff - 1'b1);
   assign col_step = (col_ff == width_ff - 1'b1) ? '0 : col_ff + 1'b1;
   assign row_step = (col_ff == width_ff - 1'b1) ? row_ff + 1'b1 : row_ff;

   always_comb begin
      phase_in   = phase_ff;
      comment_in = comment_ff;
      ovf_in     = ovf_ff;
      binary_in  = binary_ff;
      acc_in     = acc_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      res0       = '0;
      res1       = '0;
      res_count  = 2'd0;

      case (phase_ff)
         PH_EXPECT_P: begin
            if (!end_of_file && (data_byte == CH_P)) begin
               phase_in = PH_KIND;
            end else begin
               res0      = error_result(ERR_MAGIC);
               res_count = 2'd1;
               phase_in  = PH_ERROR;
            end
         end
         PH_KIND: begin
            if (!end_of_file && (data_byte == CH_TWO)) begin
               binary_in = 1'b0;
               phase_in  = PH_GAP_W;
            end else if (!end_of_file && (data_byte == CH_FIVE)) begin
               binary_in = 1'b1;
               phase_in  = PH_GAP_W;
            end else begin
               res0      = error_result(ERR_MAGIC);
               res_count = 2'd1;
               phase_in  = PH_ERROR;
            end
         end
         PH_GAP_W, PH_GAP_H, PH_GAP_M: begin
            if (gap_err) begin
               res0      = error_result(ERR_CORRUPT);
               res_count = 2'd1;
               phase_in  = PH_ERROR;
            end else if (comment_ff) begin
               if (is_crlf) begin
                  comment_in = 1'b0;
               end
            end else if (is_hash) begin
               comment_in = 1'b1;
            end else if (is_digit) begin
               acc_in   = {{(NUMBER_BITS-4){1'b0}}, digit_val};
               ovf_in   = 1'b0;
               phase_in = (phase_ff == PH_GAP_W) ? PH_NUM_W :
                          (phase_ff == PH_GAP_H) ? PH_NUM_H : PH_NUM_M;
            end
         end
         PH_NUM_W, PH_NUM_H: begin
            if (is_digit) begin
               acc_in = acc_next_digit;
               ovf_in = ovf_ff | acc_sat;
            end else if (ovf_ff) begin
               res0      = error_result(ERR_TOO_LARGE);
               res_count = 2'd1;
               phase_in  = PH_ERROR;
            end else if (acc_ff == '0) begin
               res0      = error_result((phase_ff == PH_NUM_W) ? ERR_ZERO_WIDTH
                                                                : ERR_ZERO_HEIGHT);
               res_count = 2'd1;
               phase_in  = PH_ERROR;
            end else begin
               if (phase_ff == PH_NUM_W) begin
                  width_in = acc_ff;
                  phase_in = PH_GAP_H;
               end else begin
                  height_in = acc_ff;
                  phase_in  = PH_GAP_M;
               end
               // The terminator is taken again as the first byte of the gap.
               if (gap_err) begin
                  res0      = error_result(ERR_CORRUPT);
                  res_count = 2'd1;
                  phase_in  = PH_ERROR;
               end else if (is_hash) begin
                  comment_in = 1'b1;
               end
            end
         end
         PH_NUM_M: begin
            if (is_digit) begin
               acc_in = acc_next_digit;
               ovf_in = ovf_ff | acc_sat;
            end else if (ovf_ff) begin
               res0      = error_result(ERR_TOO_LARGE);
               res_count = 2'd1;
               phase_in  = PH_ERROR;
            end else if (!is_ws) begin
               res0      = error_result(ERR_CORRUPT);
               res_count = 2'd1;
               phase_in  = PH_ERROR;
            end else begin
               res0      = header_result(fit16(width_ff), fit16(height_ff), fit16(acc_ff),
                                         binary_ff, acc_ff == '0);
               res_count = 2'd1;
               col_in    = '0;
               row_in    = '0;
               phase_in  = binary_ff ? PH_PIX_BIN : PH_PIX_GAP;
            end
         end
         PH_PIX_GAP: begin
            if (is_digit) begin
               acc_in   = {{(NUMBER_BITS-4){1'b0}}, digit_val};
               ovf_in   = 1'b0;
               phase_in = PH_PIX_NUM;
            end else if (!is_ws) begin
               res0      = error_result(ERR_CORRUPT);
               res_count = 2'd1;
               phase_in  = PH_ERROR;
            end
         end
         PH_PIX_NUM: begin
            if (is_digit) begin
               acc_in = acc_next_digit;
               ovf_in = ovf_ff | acc_sat;
            end else if (ovf_ff) begin
               res0      = error_result(ERR_TOO_LARGE);
               res_count = 2'd1;
               phase_in  = PH_ERROR;
            end else begin
               res0      = pixel_result(fit16(acc_ff), fit16(col_ff), fit16(row_ff), pix_fin);
               res_count = 2'd1;
               if (pix_fin) begin
                  phase_in = PH_DONE;
               end else begin
                  col_in = col_step;
                  row_in = row_step;
                  if (is_ws) begin
                     phase_in = PH_PIX_GAP;
                  end else begin
                     // Terminator that is neither digit nor whitespace, or end of file.
                     res1      = error_result(ERR_CORRUPT);
                     res_count = 2'd2;
                     phase_in  = PH_ERROR;
                  end
               end
            end
         end
         PH_PIX_BIN: begin
            if (end_of_file) begin
               res0      = error_result(ERR_TOO_LARGE);
               res_count = 2'd1;
               phase_in  = PH_ERROR;
            end else begin
               res0      = pixel_result({8'd0, data_byte}, fit16(col_ff), fit16(row_ff),
                                        pix_fin);
               res_count = 2'd1;
               if (pix_fin) begin
                  phase_in = PH_DONE;
               end else begin
                  col_in = col_step;
                  row_in = row_step;
               end
            end
         end
         default: begin
         end
      endcase

      if (res_count == 2'd1) begin
         res0.last = 1'b1;
      end
      if (res_count == 2'd2) begin
         res1.last = 1'b1;
      end

      // End of file always rearms the parser for the next file.
      if (end_of_file) begin
         phase_in   = PH_EXPECT_P;
         comment_in = 1'b0;
         ovf_in     = 1'b0;
         binary_in  = 1'b0;
         acc_in     = '0;
         col_in     = '0;
         row_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_EXPECT_P;
         comment_ff <= 1'b0;
         ovf_ff     <= 1'b0;
         binary_ff  <= 1'b0;
      end else if (item_valid) begin
         phase_ff   <= phase_in;
         comment_ff <= comment_in;
         ovf_ff     <= ovf_in;
         binary_ff  <= binary_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         acc_ff    <= acc_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ----- hw/rtl/psp_result_fifo.sv -----
// ----------------------------------------------------------------------------
// PGM stream parser: result queue
// Four-entry queue that takes up to two results a cycle and gives one unless the read side stalls.
// ----------------------------------------------------------------------------
module psp_result_fifo import psp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type wr0,
   input  result_type wr1,
   input  logic [1:0] wr_count,
   output logic       room,
   output logic       rd_valid,
   input  logic       rd_stall,
   output result_type rd_data
);

   result_type               entry_ff [RES_DEPTH];
   logic [RES_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RES_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RES_CNT_BITS-1:0]  count_ff, count_in;
   logic                     pop;
   logic [RES_PTR_BITS-1:0]  wr_ptr_next;

   // Room for the largest burst that one byte can give.
   assign room        = count_ff <= RES_CNT_BITS'(RES_DEPTH - MAX_RESULTS);
   assign rd_valid    = count_ff != '0;
   assign pop         = rd_valid && !rd_stall;
   assign rd_data     = entry_ff[rd_ptr_ff];
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RES_PTR_BITS'(wr_count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RES_CNT_BITS'(wr_count) - RES_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= wr0;
      end
      if (wr_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= wr1;
      end
   end

endmodule

// ----- hw/rtl/pgm_stream_parser.sv -----
// ----------------------------------------------------------------------------
// PGM stream parser
// Byte-serial parser for P2 and P5 grey-map files: header, pixels, errors.
// ----------------------------------------------------------------------------
// The parser takes one file byte (or an end-of-file mark) per beat and can
// accept a new beat in every clock cycle while req_stall is low. Each beat is
// first captured in an input register, then handled by the parse engine, whose
// results enter a four-entry result queue that drives the response channel. An
// accepted request beat passes the input register and is then written to the
// result queue, which gives its first response beat. Most bytes give no result
// or one; the byte that ends a P2 pixel with a stray character gives a pixel and
// an error, so two response beats. The sustained rate is one byte per cycle as
// long as the response side takes one beat per cycle; it is set by the result
// queue, which drains one beat a cycle and holds the input register while fewer
// than two entries are free.
module pgm_stream_parser import psp_pkg::*; #(
   parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel: one file byte per beat.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   // Response channel: one result per beat.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [15:0] rsp_max_value,
   output logic        rsp_binary_mode,
   output logic        rsp_maxval_warning,
   output logic [15:0] rsp_pixel_value,
   output logic [15:0] rsp_column,
   output logic [15:0] rsp_row,
   output logic        rsp_final_pixel,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last
);

   // Input register: the beat waiting for the parse engine.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       eof_ff;

   logic       room;
   logic       consume;
   logic       req_accept;

   result_type res0, res1, head;
   logic [1:0] res_count;

   // The held beat is consumed once the queue can take both of its results.
   // The stall depends on registered state only, so the request side never
   // sees a path from the response stall.
   assign consume    = in_valid_ff && room;
   assign req_stall  = in_valid_ff && !room;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_accept || (in_valid_ff && !consume);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         byte_ff <= req_data_byte;
         eof_ff  <= req_end_of_file;
      end
   end

   // Parse engine: state update and results for one beat.
   psp_parser #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (consume),
      .data_byte   (byte_ff),
      .end_of_file (eof_ff),
      .res0        (res0),
      .res1        (res1),
      .res_count   (res_count)
   );

   // Result queue: nothing is written unless the beat is consumed.
   psp_result_fifo u_result_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr0      (res0),
      .wr1      (res1),
      .wr_count (consume ? res_count : 2'd0),
      .room     (room),
      .rd_valid (rsp_valid),
      .rd_stall (rsp_stall),
      .rd_data  (head)
   );

   assign rsp_result_kind    = head.result_kind;
   assign rsp_image_width    = head.image_width;
   assign rsp_image_height   = head.image_height;
   assign rsp_max_value      = head.max_value;
   assign rsp_binary_mode    = head.binary_mode;
   assign rsp_maxval_warning = head.maxval_warning;
   assign rsp_pixel_value    = head.pixel_value;
   assign rsp_column         = head.column;
   assign rsp_row            = head.row;
   assign rsp_final_pixel    = head.final_pixel;
   assign rsp_error_code     = head.error_code;
   assign rsp_last           = head.last;

endmodule
